// ===== rtl/pscv_pkg.sv =====
package pscv_pkg;

   localparam int LEVEL_W = 16;
   localparam int ANGLE_W = 7;
   localparam int GAIN_W  = 24;
   localparam int RELAY_W = 8;
   localparam int PI_W    = 8;
   localparam int SUM_W   = 32;
   localparam int MODE_W  = 3;
   localparam int CSR_W   = 24;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // operating modes
   localparam logic [MODE_W-1:0] MODE_AUTO   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CLOSE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MAN1   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MAN2   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MANUAL = 3'd4;

   // register indexes
   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_SETPOINT1 = 3'd1;
   localparam logic [2:0] REG_SETPOINT2 = 3'd2;
   localparam logic [2:0] REG_GAIN_PROP = 3'd3;
   localparam logic [2:0] REG_GAIN_INTG = 3'd4;
   localparam logic [2:0] REG_RELAY_ON  = 3'd5;
   localparam logic [2:0] REG_RELAY_BND = 3'd6;
   localparam logic [2:0] REG_RELAY_REL = 3'd7;

   typedef logic signed [1:0] drive_type;
   localparam drive_type DRIVE_HOLD  = 2'sd0;
   localparam drive_type DRIVE_OPEN  = 2'sd1;
   localparam drive_type DRIVE_CLOSE = -2'sd1;

   // split points of the PI output across the two valves
   localparam logic [PI_W-1:0] SPLIT_LOW  = 8'd30;
   localparam logic [PI_W-1:0] SPLIT_MID  = 8'd60;
   localparam logic [PI_W-1:0] SPLIT_HIGH = 8'd120;

   typedef struct packed {
      logic [RELAY_W-1:0] on_lvl;
      logic [RELAY_W-1:0] band;
      logic [RELAY_W-1:0] rel_lvl;
   } relay_cfg_type;

endpackage

// ===== rtl/pi_split_three_step_valve_control_unit.sv =====
// Two-valve level controller. Each req beat carries a level and both measured
// valve angles; one rsp beat comes back per req beat with the open/hold/close
// commands, the chosen valve targets and the PI output. A beat is taken every
// cycle unless the rsp side stalls, passing the input register, then the
// result register; PI multipliers, clamp, split and relays sit in the single
// step between them. Integrator and relay history update as each beat leaves
// the input register. Write the csr registers only while no beat is in flight.
module pi_split_three_step_valve_control_unit #(
   parameter int LEVEL_TARGET_MM = 5200,
   parameter int DRIVE_LIMIT     = 180
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // level_mm[15:0], angle1[22:16], angle2[29:23], zero fill
   input  logic [pscv_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // drive1[1:0], drive2[3:2], valve1_target[10:4], valve2_target[17:11],
   // pi_drive[25:18], zero fill
   output logic [pscv_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [2:0]                          csr_index,
   input  logic [pscv_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int AW = pscv_pkg::ANGLE_W;

   // configuration
   logic [pscv_pkg::MODE_W-1:0]  mode_ff;
   logic [AW-1:0]                setpoint1_ff;
   logic [AW-1:0]                setpoint2_ff;
   logic [pscv_pkg::GAIN_W-1:0]  gain_prop_ff;
   logic [pscv_pkg::GAIN_W-1:0]  gain_integ_ff;
   pscv_pkg::relay_cfg_type      relay_cfg_ff;

   // pipeline
   logic                         in_valid_ff;
   logic [pscv_pkg::LEVEL_W-1:0] level_ff;
   logic [AW-1:0]                angle1_ff;
   logic [AW-1:0]                angle2_ff;
   logic                         out_valid_ff;
   logic [pscv_pkg::RSP_DATA_W-1:0] out_data_ff;
   logic [pscv_pkg::RSP_DATA_W-1:0] out_data_in;

   // history
   logic signed [pscv_pkg::SUM_W-1:0] error_sum_ff;
   logic signed [pscv_pkg::SUM_W-1:0] error_sum_in;
   pscv_pkg::drive_type          drive1_ff;
   pscv_pkg::drive_type          drive2_ff;
   pscv_pkg::drive_type          drive1_in;
   pscv_pkg::drive_type          drive2_in;

   logic                         out_free;
   logic                         advance;
   logic [pscv_pkg::PI_W-1:0]    pi_raw;
   logic [pscv_pkg::PI_W-1:0]    pi_drive;
   logic [AW-1:0]                target1;
   logic [AW-1:0]                target2;
   logic signed [pscv_pkg::SUM_W-1:0] error_sum_next;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff              <= pscv_pkg::MODE_AUTO;
         setpoint1_ff         <= 7'd60;
         setpoint2_ff         <= 7'd60;
         gain_prop_ff         <= 24'd19661;
         gain_integ_ff        <= 24'd66;
         relay_cfg_ff.on_lvl  <= 8'd2;
         relay_cfg_ff.band    <= 8'd4;
         relay_cfg_ff.rel_lvl <= 8'd1;
      end else if (csr_we) begin
         case (csr_index)
            pscv_pkg::REG_MODE:      mode_ff       <= csr_wdata[pscv_pkg::MODE_W-1:0];
            pscv_pkg::REG_SETPOINT1: setpoint1_ff  <= csr_wdata[AW-1:0];
            pscv_pkg::REG_SETPOINT2: setpoint2_ff  <= csr_wdata[AW-1:0];
            pscv_pkg::REG_GAIN_PROP: gain_prop_ff  <= csr_wdata[pscv_pkg::GAIN_W-1:0];
            pscv_pkg::REG_GAIN_INTG: gain_integ_ff <= csr_wdata[pscv_pkg::GAIN_W-1:0];
            pscv_pkg::REG_RELAY_ON:  relay_cfg_ff.on_lvl  <= csr_wdata[pscv_pkg::RELAY_W-1:0];
            pscv_pkg::REG_RELAY_BND: relay_cfg_ff.band    <= csr_wdata[pscv_pkg::RELAY_W-1:0];
            pscv_pkg::REG_RELAY_REL: relay_cfg_ff.rel_lvl <= csr_wdata[pscv_pkg::RELAY_W-1:0];
            default: ;
         endcase
      end
   end

   pscv_pi #(
      .LEVEL_TARGET_MM (LEVEL_TARGET_MM),
      .DRIVE_LIMIT     (DRIVE_LIMIT)
   ) u_pi (
      .level_mm       (level_ff),
      .gain_prop      (gain_prop_ff),
      .gain_integ     (gain_integ_ff),
      .error_sum      (error_sum_ff),
      .pi_drive       (pi_raw),
      .error_sum_next (error_sum_next)
   );

   always_comb begin
      pi_drive     = '0;
      target1      = '0;
      target2      = '0;
      error_sum_in = error_sum_ff;
      case (mode_ff)
         pscv_pkg::MODE_AUTO: begin
            pi_drive     = pi_raw;
            error_sum_in = error_sum_next;
            if (pi_raw < pscv_pkg::SPLIT_LOW) begin
               target1 = '0;
               target2 = '0;
            end else if (pi_raw <= pscv_pkg::SPLIT_MID) begin
               target1 = pi_raw[AW-1:0];
               target2 = '0;
            end else if (pi_raw <= pscv_pkg::SPLIT_HIGH) begin
               target1 = pscv_pkg::SPLIT_MID[AW-1:0];
               target2 = AW'(pi_raw - pscv_pkg::SPLIT_MID);
            end else begin
               target1 = pi_raw[AW:1];
               target2 = pi_raw[AW:1];
            end
         end
         pscv_pkg::MODE_MAN1: begin
            target1 = setpoint1_ff;
            target2 = angle2_ff;
         end
         pscv_pkg::MODE_MAN2: begin
            target1 = angle1_ff;
            target2 = setpoint2_ff;
         end
         pscv_pkg::MODE_MANUAL: begin
            target1 = setpoint1_ff;
            target2 = setpoint2_ff;
         end
         default: ;
      endcase
   end

   pscv_relay u_relay1 (
      .target (target1),
      .angle  (angle1_ff),
      .prev   (drive1_ff),
      .cfg    (relay_cfg_ff),
      .drive  (drive1_in)
   );

   pscv_relay u_relay2 (
      .target (target2),
      .angle  (angle2_ff),
      .prev   (drive2_ff),
      .cfg    (relay_cfg_ff),
      .drive  (drive2_in)
   );

   assign out_data_in = {6'b000000, pi_drive, target2, target1, drive2_in, drive1_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         error_sum_ff <= '0;
         drive1_ff    <= pscv_pkg::DRIVE_HOLD;
         drive2_ff    <= pscv_pkg::DRIVE_HOLD;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            error_sum_ff <= error_sum_in;
            drive1_ff    <= drive1_in;
            drive2_ff    <= drive2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         level_ff  <= req_tdata[15:0];
         angle1_ff <= req_tdata[22:16];
         angle2_ff <= req_tdata[29:23];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// ===== rtl/pscv_pi.sv =====
module pscv_pi #(
   parameter int LEVEL_TARGET_MM = 5200,
   parameter int DRIVE_LIMIT     = 180
) (
   input  logic        [pscv_pkg::LEVEL_W-1:0] level_mm,
   input  logic        [pscv_pkg::GAIN_W-1:0]  gain_prop,
   input  logic        [pscv_pkg::GAIN_W-1:0]  gain_integ,
   input  logic signed [pscv_pkg::SUM_W-1:0]   error_sum,
   output logic        [pscv_pkg::PI_W-1:0]    pi_drive,
   output logic signed [pscv_pkg::SUM_W-1:0]   error_sum_next
);

   localparam int ERR_W  = pscv_pkg::LEVEL_W + 1;
   localparam int ACC_W  = pscv_pkg::SUM_W + 1;
   localparam int PP_W   = pscv_pkg::GAIN_W + 1 + ERR_W;
   localparam int PI_PW  = pscv_pkg::GAIN_W + 1 + ACC_W;
   localparam int TOT_W  = PI_PW + 1;
   localparam logic [TOT_W-1:0] LIMIT_Q16 = TOT_W'(DRIVE_LIMIT) << 16;

   logic signed [ERR_W-1:0] err;
   logic signed [ACC_W-1:0] acc;
   logic signed [PP_W-1:0]  prod_p;
   logic signed [PI_PW-1:0] prod_i;
   logic signed [TOT_W-1:0] total;
   logic        [TOT_W-1:0] neg;

   assign err = $signed({1'b0, pscv_pkg::LEVEL_W'(LEVEL_TARGET_MM)})
              - $signed({1'b0, level_mm});
   assign acc = $signed({{(ACC_W-ERR_W){err[ERR_W-1]}}, err})
              + $signed({error_sum[pscv_pkg::SUM_W-1], error_sum});

   assign prod_p = $signed({1'b0, gain_prop}) * err;
   assign prod_i = $signed({1'b0, gain_integ}) * acc;

   assign total = $signed({{(TOT_W-PP_W){prod_p[PP_W-1]}}, prod_p})
                + $signed({prod_i[PI_PW-1], prod_i});
   assign neg   = $unsigned(-total);

   // drive is the negated sum clamped to 0..limit, Q16 truncated
   always_comb begin
      if (!total[TOT_W-1]) begin
         pi_drive = '0;
      end else if (neg >= LIMIT_Q16) begin
         pi_drive = pscv_pkg::PI_W'(DRIVE_LIMIT);
      end else begin
         pi_drive = neg[16 +: pscv_pkg::PI_W];
      end
   end

   always_comb begin
      if (acc[ACC_W-1] != acc[ACC_W-2]) begin
         error_sum_next = acc[ACC_W-1] ? $signed({1'b1, {(pscv_pkg::SUM_W-1){1'b0}}})
                                       : $signed({1'b0, {(pscv_pkg::SUM_W-1){1'b1}}});
      end else begin
         error_sum_next = acc[pscv_pkg::SUM_W-1:0];
      end
   end

endmodule

// ===== rtl/pscv_relay.sv =====
module pscv_relay (
   input  logic [pscv_pkg::ANGLE_W-1:0] target,
   input  logic [pscv_pkg::ANGLE_W-1:0] angle,
   input  pscv_pkg::drive_type          prev,
   input  pscv_pkg::relay_cfg_type      cfg,
   output pscv_pkg::drive_type          drive
);

   localparam int DIFF_W = pscv_pkg::ANGLE_W + 3;
   localparam int CMP_W  = pscv_pkg::RELAY_W + 3;

   logic signed [DIFF_W-1:0] diff;
   logic signed [CMP_W-1:0]  err2;
   logic signed [CMP_W-1:0]  on_thr;
   logic signed [CMP_W-1:0]  rel_thr;
   logic signed [CMP_W-1:0]  close_thr;
   logic signed [CMP_W-1:0]  hold_thr;

   assign diff = $signed({3'b000, target}) - $signed({3'b000, angle});
   // error in half degrees
   assign err2 = $signed({{(CMP_W-DIFF_W){diff[DIFF_W-1]}}, diff}) <<< 1;

   assign on_thr    = $signed({3'b000, cfg.on_lvl});
   assign rel_thr   = $signed({3'b000, cfg.rel_lvl});
   assign close_thr = -($signed({3'b000, cfg.band}) + on_thr);
   assign hold_thr  = -($signed({3'b000, cfg.band}) + rel_thr);

   always_comb begin
      case (prev)
         pscv_pkg::DRIVE_OPEN: begin
            drive = (err2 > rel_thr) ? pscv_pkg::DRIVE_OPEN : pscv_pkg::DRIVE_HOLD;
         end
         pscv_pkg::DRIVE_HOLD: begin
            if (err2 >= on_thr) begin
               drive = pscv_pkg::DRIVE_OPEN;
            end else if (err2 <= close_thr) begin
               drive = pscv_pkg::DRIVE_CLOSE;
            end else begin
               drive = pscv_pkg::DRIVE_HOLD;
            end
         end
         default: begin
            drive = (err2 >= hold_thr) ? pscv_pkg::DRIVE_HOLD : pscv_pkg::DRIVE_CLOSE;
         end
      endcase
   end

endmodule

// ===== rtl/pscv_checker.sv =====
module pscv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid straight after reset");

   a_drive_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'b10 && rsp_tdata[3:2] != 2'b10
                     && rsp_tdata[31:26] == 6'd0)
      else $error("bad drive code or fill bits");

   a_pi_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:18] <= 8'd180)
      else $error("pi drive above limit");

   // no result without an earlier accepted item
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("rsp beat without a req beat");

endmodule

bind pi_split_three_step_valve_control_unit pscv_checker u_pscv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/valve_command_checker.sv =====
`timescale 1ns / 100ps

module valve_command_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // level_mm[15:0], angle1[22:16], angle2[29:23], zero fill
   input  logic [pscv_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // drive1[1:0], drive2[3:2], valve1_target[10:4], valve2_target[17:11],
   // pi_drive[25:18], zero fill
   input  logic [pscv_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [2:0]                      csr_index,
   input  logic [pscv_pkg::CSR_W-1:0]      csr_wdata,
   output int                              mismatch_count,
   output int                              cmds_in_flight
);

   localparam longint LEVEL_TARGET_MM = 5200;
   localparam longint DRIVE_LIMIT     = 180;
   localparam longint Q16_ONE         = 65536;
   localparam longint SUM_MAX         = 64'sd2147483647;
   localparam longint SUM_MIN         = -64'sd2147483648;

   // same bit layout as rsp_tdata[25:0]
   typedef struct packed {
      logic [pscv_pkg::PI_W-1:0]    pi_drive;
      logic [pscv_pkg::ANGLE_W-1:0] target2;
      logic [pscv_pkg::ANGLE_W-1:0] target1;
      pscv_pkg::drive_type          drive2;
      pscv_pkg::drive_type          drive1;
   } valve_cmd_type;

   logic [pscv_pkg::MODE_W-1:0]  cfg_mode;
   logic [pscv_pkg::ANGLE_W-1:0] cfg_setpoint1;
   logic [pscv_pkg::ANGLE_W-1:0] cfg_setpoint2;
   logic [pscv_pkg::GAIN_W-1:0]  cfg_gain_p;
   logic [pscv_pkg::GAIN_W-1:0]  cfg_gain_i;
   pscv_pkg::relay_cfg_type      cfg_relay;

   longint              integ_sum;
   pscv_pkg::drive_type held_drive1;
   pscv_pkg::drive_type held_drive2;

   valve_cmd_type pending_cmds[$];

   // three-position relay; err2 is the angle error in half degrees
   function automatic pscv_pkg::drive_type relay_next(int err2, pscv_pkg::drive_type prev);
      int on_lvl;
      int band;
      int rel_lvl;
      on_lvl  = int'(cfg_relay.on_lvl);
      band    = int'(cfg_relay.band);
      rel_lvl = int'(cfg_relay.rel_lvl);
      if (prev == pscv_pkg::DRIVE_OPEN)
         return (err2 > rel_lvl) ? pscv_pkg::DRIVE_OPEN : pscv_pkg::DRIVE_HOLD;
      if (prev == pscv_pkg::DRIVE_HOLD) begin
         if (err2 >= on_lvl)
            return pscv_pkg::DRIVE_OPEN;
         if (err2 <= -(band + on_lvl))
            return pscv_pkg::DRIVE_CLOSE;
         return pscv_pkg::DRIVE_HOLD;
      end
      return (err2 >= -(band + rel_lvl)) ? pscv_pkg::DRIVE_HOLD : pscv_pkg::DRIVE_CLOSE;
   endfunction

   function automatic valve_cmd_type next_valve_cmds(logic [pscv_pkg::LEVEL_W-1:0] level,
                                                     logic [pscv_pkg::ANGLE_W-1:0] ang1,
                                                     logic [pscv_pkg::ANGLE_W-1:0] ang2);
      valve_cmd_type cmd;
      longint        err;
      longint        acc;
      longint        demand;
      int            pi_deg;
      int            tgt1;
      int            tgt2;
      pi_deg = 0;
      tgt1   = 0;
      tgt2   = 0;
      case (cfg_mode)
         pscv_pkg::MODE_AUTO: begin
            err    = LEVEL_TARGET_MM - longint'(level);
            acc    = longint'(cfg_gain_p) * err + longint'(cfg_gain_i) * (err + integ_sum);
            demand = -acc;
            if (demand < 0)
               demand = 0;
            else if (demand > DRIVE_LIMIT * Q16_ONE)
               demand = DRIVE_LIMIT * Q16_ONE;
            pi_deg = int'(demand / Q16_ONE);
            // integrates even while clamped, saturating at 32 bits
            integ_sum = integ_sum + err;
            if (integ_sum > SUM_MAX)
               integ_sum = SUM_MAX;
            else if (integ_sum < SUM_MIN)
               integ_sum = SUM_MIN;
            if (pi_deg < int'(pscv_pkg::SPLIT_LOW)) begin
               tgt1 = 0;
               tgt2 = 0;
            end else if (pi_deg <= int'(pscv_pkg::SPLIT_MID)) begin
               tgt1 = pi_deg;
            end else if (pi_deg <= int'(pscv_pkg::SPLIT_HIGH)) begin
               tgt1 = int'(pscv_pkg::SPLIT_MID);
               tgt2 = pi_deg - int'(pscv_pkg::SPLIT_MID);
            end else begin
               tgt1 = pi_deg / 2;
               tgt2 = tgt1;
            end
         end
         pscv_pkg::MODE_MAN1: begin
            tgt1 = int'(cfg_setpoint1);
            tgt2 = int'(ang2);
         end
         pscv_pkg::MODE_MAN2: begin
            tgt1 = int'(ang1);
            tgt2 = int'(cfg_setpoint2);
         end
         pscv_pkg::MODE_MANUAL: begin
            tgt1 = int'(cfg_setpoint1);
            tgt2 = int'(cfg_setpoint2);
         end
         default: ;
      endcase
      held_drive1 = relay_next(2 * (tgt1 - int'(ang1)), held_drive1);
      held_drive2 = relay_next(2 * (tgt2 - int'(ang2)), held_drive2);
      cmd.drive1   = held_drive1;
      cmd.drive2   = held_drive2;
      cmd.target1  = tgt1[pscv_pkg::ANGLE_W-1:0];
      cmd.target2  = tgt2[pscv_pkg::ANGLE_W-1:0];
      cmd.pi_drive = pi_deg[pscv_pkg::PI_W-1:0];
      return cmd;
   endfunction

   task automatic check_field(string what, int want, int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      valve_cmd_type seen;
      valve_cmd_type want;
      if (reset) begin
         cfg_mode          = pscv_pkg::MODE_AUTO;
         cfg_setpoint1     = 7'd60;
         cfg_setpoint2     = 7'd60;
         cfg_gain_p        = 24'd19661;
         cfg_gain_i        = 24'd66;
         cfg_relay.on_lvl  = 8'd2;
         cfg_relay.band    = 8'd4;
         cfg_relay.rel_lvl = 8'd1;
         integ_sum         = 0;
         held_drive1       = pscv_pkg::DRIVE_HOLD;
         held_drive2       = pscv_pkg::DRIVE_HOLD;
         pending_cmds.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               pscv_pkg::REG_MODE:
                  cfg_mode = csr_wdata[pscv_pkg::MODE_W-1:0];
               pscv_pkg::REG_SETPOINT1:
                  cfg_setpoint1 = csr_wdata[pscv_pkg::ANGLE_W-1:0];
               pscv_pkg::REG_SETPOINT2:
                  cfg_setpoint2 = csr_wdata[pscv_pkg::ANGLE_W-1:0];
               pscv_pkg::REG_GAIN_PROP:
                  cfg_gain_p = csr_wdata[pscv_pkg::GAIN_W-1:0];
               pscv_pkg::REG_GAIN_INTG:
                  cfg_gain_i = csr_wdata[pscv_pkg::GAIN_W-1:0];
               pscv_pkg::REG_RELAY_ON:
                  cfg_relay.on_lvl = csr_wdata[pscv_pkg::RELAY_W-1:0];
               pscv_pkg::REG_RELAY_BND:
                  cfg_relay.band = csr_wdata[pscv_pkg::RELAY_W-1:0];
               pscv_pkg::REG_RELAY_REL:
                  cfg_relay.rel_lvl = csr_wdata[pscv_pkg::RELAY_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_cmds.push_back(next_valve_cmds(req_tdata[15:0], req_tdata[22:16],
                                                   req_tdata[29:23]));
         if (rsp_tvalid && rsp_tready) begin
            seen = valve_cmd_type'(rsp_tdata[25:0]);
            if (pending_cmds.size() == 0) begin
               mismatch_count++;
               $display("%0t: rsp beat expected none got %h", $time, rsp_tdata);
            end else begin
               want = pending_cmds.pop_front();
               check_field("drive1", int'(want.drive1), int'(seen.drive1));
               check_field("drive2", int'(want.drive2), int'(seen.drive2));
               check_field("valve1_target", int'(want.target1), int'(seen.target1));
               check_field("valve2_target", int'(want.target2), int'(seen.target2));
               check_field("pi_drive", int'(want.pi_drive), int'(seen.pi_drive));
            end
         end
      end
      cmds_in_flight = pending_cmds.size();
   end

endmodule

// ===== tb/tb_pi_split_three_step_valve_control_unit.sv =====
`timescale 1ns / 100ps

module tb_pi_split_three_step_valve_control_unit;

   localparam int LEVEL_TARGET_MM = 5200;
   localparam int RANDOM_ITEMS    = 1350;
   localparam int BURST_ITEMS     = 40;
   localparam int SETTLE_CYCLES   = 4;

   localparam logic [pscv_pkg::MODE_W-1:0] MODE_UNUSED_LAST = 3'd7;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [pscv_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [pscv_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we     = 1'b0;
   logic [2:0]                      csr_index  = pscv_pkg::REG_MODE;
   logic [pscv_pkg::CSR_W-1:0]      csr_wdata  = '0;

   int mismatch_count;
   int cmds_in_flight;

   // shadows kept only to steer the stimulus
   logic [pscv_pkg::MODE_W-1:0] cur_mode  = pscv_pkg::MODE_AUTO;
   int                          cur_sp1   = 60;
   int                          cur_sp2   = 60;
   longint                      err_tally = 0;
   int                          ang1_walk = 45;
   int                          ang2_walk = 45;

   bit tx_calm  = 1'b0;
   bit tx_flood = 1'b0;
   bit rx_calm  = 1'b0;
   int rx_stall = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pi_split_three_step_valve_control_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   valve_command_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .cmds_in_flight (cmds_in_flight)
   );

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0)
         rx_calm = !rx_calm;
      if (rx_stall > 0) begin
         rsp_tready <= 1'b0;
         rx_stall--;
      end else if (rx_calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rx_stall = pick_gap();
         rsp_tready <= (rx_stall == 0);
         if (rx_stall > 0)
            rx_stall--;
      end
   end

   task automatic write_reg(logic [2:0] index, logic [pscv_pkg::CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         pscv_pkg::REG_MODE:      cur_mode = value[pscv_pkg::MODE_W-1:0];
         pscv_pkg::REG_SETPOINT1: cur_sp1 = int'(value[pscv_pkg::ANGLE_W-1:0]);
         pscv_pkg::REG_SETPOINT2: cur_sp2 = int'(value[pscv_pkg::ANGLE_W-1:0]);
         default: ;
      endcase
   endtask

   // hold_after leaves the channel idle once the beat is taken
   task automatic send_item(logic [pscv_pkg::LEVEL_W-1:0] level,
                            logic [pscv_pkg::ANGLE_W-1:0] ang1,
                            logic [pscv_pkg::ANGLE_W-1:0] ang2, bit hold_after);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, ang2, ang1, level};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (cur_mode == pscv_pkg::MODE_AUTO)
         err_tally += LEVEL_TARGET_MM - int'(level);
      if ($urandom_range(0, 49) == 0)
         tx_calm = !tx_calm;
      gap = (tx_calm || tx_flood) ? 0 : pick_gap();
      if (hold_after && gap == 0)
         gap = 1;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (cmds_in_flight != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // near the target most of the time, pulled against the integrator so that
   // the PI output keeps sweeping the split regions
   function automatic logic [pscv_pkg::LEVEL_W-1:0] pick_level();
      int roll;
      int pull;
      int lvl;
      roll = $urandom_range(0, 99);
      if (roll < 3 || (cur_mode != pscv_pkg::MODE_AUTO && roll < 50))
         return pscv_pkg::LEVEL_W'($urandom_range(0, 65535));
      if (roll < 5)
         return '0;
      if (roll < 6)
         return '1;
      pull = int'(err_tally / 16);
      if (pull > 2000)
         pull = 2000;
      else if (pull < -2000)
         pull = -2000;
      lvl = LEVEL_TARGET_MM + pull + int'($urandom_range(0, 1600)) - 800;
      return lvl[pscv_pkg::LEVEL_W-1:0];
   endfunction

   // valve angles drift slowly, with the odd jump
   function automatic int step_angle(int pos, int setp);
      int roll;
      int nxt;
      roll = $urandom_range(0, 99);
      if (roll < 8)
         return $urandom_range(0, 90);
      if (roll < 12)
         return (setp > 90) ? 90 : setp;
      nxt = pos + int'($urandom_range(0, 4)) - 2;
      if (nxt < 0)
         nxt = 0;
      else if (nxt > 90)
         nxt = 90;
      return nxt;
   endfunction

   function automatic logic [pscv_pkg::CSR_W-1:0] pick_reg_value(int index);
      int roll;
      roll = $urandom_range(0, 99);
      case (index)
         pscv_pkg::REG_SETPOINT1, pscv_pkg::REG_SETPOINT2: begin
            if (roll < 12)
               return pscv_pkg::CSR_W'($urandom_range(91, 127));
            if (roll < 20)
               return '0;
            if (roll < 28)
               return 90;
            return pscv_pkg::CSR_W'($urandom_range(0, 90));
         end
         pscv_pkg::REG_GAIN_PROP, pscv_pkg::REG_GAIN_INTG: begin
            if (roll < 10)
               return '0;
            if (roll < 20)
               return '1;
            return (index == pscv_pkg::REG_GAIN_PROP)
                   ? pscv_pkg::CSR_W'($urandom_range(0, 1 << 17))
                   : pscv_pkg::CSR_W'($urandom_range(0, 600));
         end
         default: begin
            if (roll < 12)
               return '0;
            if (roll < 24)
               return 255;
            return pscv_pkg::CSR_W'($urandom_range(0, 12));
         end
      endcase
   endfunction

   task automatic shuffle_config(bit every_reg);
      for (int i = pscv_pkg::REG_SETPOINT1; i <= pscv_pkg::REG_RELAY_REL; i++)
         if (every_reg || $urandom_range(0, 1) == 1)
            write_reg(3'(i), pick_reg_value(i));
      if ($urandom_range(0, 99) < 45)
         write_reg(pscv_pkg::REG_MODE, pscv_pkg::CSR_W'(pscv_pkg::MODE_AUTO));
      else
         write_reg(pscv_pkg::REG_MODE,
                   pscv_pkg::CSR_W'($urandom_range(pscv_pkg::MODE_CLOSE, MODE_UNUSED_LAST)));
   endtask

   initial begin
      int n;
      int done;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // auto at reset settings: every split region, clamp and both extremes
      send_item(16'd5200, 7'd0, 7'd0, 1'b0);
      send_item(16'd5300, 7'd0, 7'd0, 1'b0);
      send_item(16'd5400, 7'd30, 7'd0, 1'b0);
      send_item(16'd5500, 7'd60, 7'd0, 1'b0);
      send_item(16'd5700, 7'd60, 7'd45, 1'b0);
      send_item(16'hFFFF, 7'd90, 7'd90, 1'b0);
      send_item(16'd0, 7'd63, 7'd64, 1'b0);
      send_item(16'd5250, 7'd90, 7'd90, 1'b1);

      // manual modes, with a setpoint beyond 90
      wait_idle();
      write_reg(pscv_pkg::REG_SETPOINT1, 127);
      write_reg(pscv_pkg::REG_MODE, pscv_pkg::CSR_W'(pscv_pkg::MODE_MAN1));
      send_item(16'h2000, 7'd64, 7'd63, 1'b0);
      send_item(16'h8000, 7'd0, 7'd90, 1'b1);
      wait_idle();
      write_reg(pscv_pkg::REG_SETPOINT2, 0);
      write_reg(pscv_pkg::REG_MODE, pscv_pkg::CSR_W'(pscv_pkg::MODE_MAN2));
      send_item(16'h4000, 7'd90, 7'd0, 1'b0);
      send_item(16'h1234, 7'd10, 7'd90, 1'b1);
      wait_idle();
      write_reg(pscv_pkg::REG_SETPOINT1, 90);
      write_reg(pscv_pkg::REG_MODE, pscv_pkg::CSR_W'(pscv_pkg::MODE_MANUAL));
      send_item(16'hABCD, 7'd0, 7'd90, 1'b0);
      send_item(16'h5555, 7'd90, 7'd0, 1'b1);

      // close and the unused modes all close both valves
      for (int m = pscv_pkg::MODE_CLOSE; m <= MODE_UNUSED_LAST; m++) begin
         if (m == pscv_pkg::MODE_MAN1)
            m = pscv_pkg::MODE_MANUAL + 1;
         wait_idle();
         write_reg(pscv_pkg::REG_MODE, pscv_pkg::CSR_W'(m));
         send_item(pscv_pkg::LEVEL_W'($urandom_range(0, 65535)), 7'd45, 7'd45, 1'b1);
      end

      done = 0;
      while (done < RANDOM_ITEMS) begin
         wait_idle();
         shuffle_config(done == 0);
         n = $urandom_range(30, 110);
         for (int k = 0; k < n; k++) begin
            ang1_walk = step_angle(ang1_walk, cur_sp1);
            ang2_walk = step_angle(ang2_walk, cur_sp2);
            send_item(pick_level(), ang1_walk[pscv_pkg::ANGLE_W-1:0],
                      ang2_walk[pscv_pkg::ANGLE_W-1:0], k == n - 1);
         end
         done += n;
      end

      // back-to-back burst far above the target; with the proportional gain
      // off the output follows the integrator alone
      wait_idle();
      write_reg(pscv_pkg::REG_GAIN_PROP, 0);
      write_reg(pscv_pkg::REG_GAIN_INTG, 1);
      write_reg(pscv_pkg::REG_MODE, pscv_pkg::CSR_W'(pscv_pkg::MODE_AUTO));
      tx_flood = 1'b1;
      for (int k = 0; k < BURST_ITEMS; k++)
         send_item(16'hFFFF, pscv_pkg::ANGLE_W'($urandom_range(0, 90)),
                   pscv_pkg::ANGLE_W'($urandom_range(0, 90)), k == BURST_ITEMS - 1);
      tx_flood = 1'b0;
      for (int k = 0; k < 8; k++)
         send_item(16'd0, pscv_pkg::ANGLE_W'($urandom_range(0, 90)),
                   pscv_pkg::ANGLE_W'($urandom_range(0, 90)), k == 7);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_pi_split_three_step_valve_control_unit OK");
      else
         $display("tb_pi_split_three_step_valve_control_unit NOT OK");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("tb_pi_split_three_step_valve_control_unit NOT OK");
      $finish;
   end

endmodule
